>>> rtl/core/itrd_pkg.sv
// Shared constants, beat types and controller interface types for the radix digit formatter.
`default_nettype none
package itrd_pkg;

	localparam int MAX_SYMBOLS = 128;
	localparam int MAX_DIGITS  = 32;
	localparam int DATA_W      = 32;
	localparam int SYM_W       = 8;

	localparam int IDX_W = $clog2(MAX_SYMBOLS);
	localparam int LEN_W = $clog2(MAX_SYMBOLS + 1);
	localparam int DIG_W = IDX_W;
	localparam int REM_W = IDX_W;
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int SP_W  = $clog2(MAX_DIGITS);
	localparam int BIT_W = $clog2(DATA_W);

	localparam logic [SYM_W-1:0] SYM_PLUS    = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_MINUS   = 8'h2D;
	localparam logic [SYM_W-1:0] SYM_PERCENT = 8'h25;
	localparam logic [SYM_W-1:0] SYM_SLASH   = 8'h2F;
	localparam logic [SYM_W-1:0] SYM_STAR    = 8'h2A;
	localparam logic [SYM_W-1:0] SYM_EQUAL   = 8'h3D;
	localparam logic [SYM_W-1:0] SYM_COMMA   = 8'h2C;
	localparam logic [SYM_W-1:0] SYM_DOT     = 8'h2E;
	localparam logic [SYM_W-1:0] SYM_LOW     = 8'd33;
	localparam logic [SYM_W-1:0] SYM_HIGH    = 8'd126;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_APPEND  = 2'd1,
		OP_CONVERT = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]               op;
		logic [SYM_W-1:0]         symbol_in;
		logic signed [DATA_W-1:0] number;
	} item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol_out;
		logic             last;
		logic             error;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_WRITE,
		ST_ERR,
		ST_DIV,
		ST_PUSH,
		ST_SIGN,
		ST_POP,
		ST_LOOKUP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take;
		logic scan_read;
		logic scan_cmp;
		logic write_sym;
		logic div_step;
		logic push;
		logic pop;
		logic lookup;
		logic load_sign;
		logic load_digit;
		logic load_err;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic len_zero;
		logic invalid;
		logic neg;
		logic scan_last;
		logic bit_last;
		logic mag_zero;
		logic count_zero;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/core/itrd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module itrd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/itrd_ctrl.sv
// Sequencing state machine for alphabet loading, digit division and symbol output.
`default_nettype none
module itrd_ctrl import itrd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	input  wire logic [1:0] item_op,
	input  wire sts_t       sts,
	output logic            item_stall,
	output cmd_t            cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					unique case (item_op)
						OP_APPEND: begin
							if (sts.full) begin
								state_d = ST_IDLE;
							end else if (sts.len_zero) begin
								state_d = ST_WRITE;
							end else begin
								state_d = ST_SCAN_RD;
							end
						end
						OP_CONVERT: begin
							state_d = sts.invalid ? ST_ERR : ST_DIV;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SCAN_RD:  state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: state_d = sts.scan_last ? ST_WRITE : ST_SCAN_RD;
			ST_WRITE:    state_d = ST_IDLE;
			ST_ERR:      state_d = sts.out_free ? ST_IDLE : ST_ERR;
			ST_DIV:      state_d = sts.bit_last ? ST_PUSH : ST_DIV;
			ST_PUSH: begin
				if (!sts.mag_zero) begin
					state_d = ST_DIV;
				end else begin
					state_d = sts.neg ? ST_SIGN : ST_POP;
				end
			end
			ST_SIGN:   state_d = sts.out_free ? ST_POP : ST_SIGN;
			ST_POP:    state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = sts.count_zero ? ST_IDLE : ST_POP;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:     cmd.take       = item_valid;
			ST_SCAN_RD:  cmd.scan_read  = 1'b1;
			ST_SCAN_CMP: cmd.scan_cmp   = 1'b1;
			ST_WRITE:    cmd.write_sym  = 1'b1;
			ST_ERR:      cmd.load_err   = sts.out_free;
			ST_DIV:      cmd.div_step   = 1'b1;
			ST_PUSH:     cmd.push       = 1'b1;
			ST_SIGN:     cmd.load_sign  = sts.out_free;
			ST_POP:      cmd.pop        = 1'b1;
			ST_LOOKUP:   cmd.lookup     = 1'b1;
			ST_EMIT:     cmd.load_digit = sts.out_free;
			default:     cmd            = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/core/itrd_dp.sv
// Datapath: alphabet store, restoring divider, digit stack and output register.
`default_nettype none
module itrd_dp import itrd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t item,
	input  wire logic  result_stall,
	input  wire cmd_t  cmd,
	output sts_t       sts,
	output result_t    result,
	output logic       result_valid
);

	logic [LEN_W-1:0]  len_q;
	logic              bad_q;
	logic [SYM_W-1:0]  sym_q;
	logic [IDX_W-1:0]  idx_q;
	logic              neg_q;
	logic [DATA_W-1:0] mag_q;
	logic [REM_W-1:0]  rem_q;
	logic [BIT_W-1:0]  bitcnt_q;
	logic [CNT_W-1:0]  count_q;
	result_t           result_q;
	logic              result_valid_q;

	logic [DATA_W-1:0] num_u;
	logic [DATA_W-1:0] num_mag;
	logic [REM_W:0]    trial;
	logic [REM_W:0]    diff;
	logic              q_bit;
	logic [REM_W-1:0]  rem_next;
	logic [CNT_W-1:0]  pop_ptr;
	logic              stack_room;
	logic              forbidden;

	logic [SYM_W-1:0]  alpha_rdata;
	logic [IDX_W-1:0]  alpha_raddr;
	logic [DIG_W-1:0]  stack_rdata;

	function automatic logic symbol_forbidden(input logic [SYM_W-1:0] s);
		return (s < SYM_LOW) || (s > SYM_HIGH) || (s == SYM_PLUS) || (s == SYM_MINUS) ||
			(s == SYM_PERCENT) || (s == SYM_SLASH) || (s == SYM_STAR) ||
			(s == SYM_EQUAL) || (s == SYM_COMMA) || (s == SYM_DOT);
	endfunction

	assign num_u     = DATA_W'(unsigned'(item.number));
	assign num_mag   = item.number[DATA_W-1] ? (~num_u + DATA_W'(1)) : num_u;
	assign forbidden = symbol_forbidden(item.symbol_in);

	// One restoring division step: shift the next dividend bit into the remainder.
	assign trial    = {rem_q, mag_q[DATA_W-1]};
	assign q_bit    = (trial >= (REM_W+1)'(len_q));
	assign diff     = trial - (REM_W+1)'(len_q);
	assign rem_next = q_bit ? diff[REM_W-1:0] : trial[REM_W-1:0];

	assign pop_ptr    = count_q - CNT_W'(1);
	assign stack_room = (count_q < CNT_W'(MAX_DIGITS));
	assign alpha_raddr = cmd.lookup ? stack_rdata : idx_q;

	itrd_ram #(
		.WIDTH(SYM_W),
		.DEPTH(MAX_SYMBOLS)
	) u_alpha (
		.clk  (clk),
		.we   (cmd.write_sym),
		.waddr(len_q[IDX_W-1:0]),
		.wdata(sym_q),
		.re   (cmd.scan_read | cmd.lookup),
		.raddr(alpha_raddr),
		.rdata(alpha_rdata)
	);

	itrd_ram #(
		.WIDTH(DIG_W),
		.DEPTH(MAX_DIGITS)
	) u_stack (
		.clk  (clk),
		.we   (cmd.push & stack_room),
		.waddr(count_q[SP_W-1:0]),
		.wdata(rem_q[DIG_W-1:0]),
		.re   (cmd.pop),
		.raddr(pop_ptr[SP_W-1:0]),
		.rdata(stack_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q          <= '0;
			bad_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				case (item.op)
					OP_CLEAR: begin
						len_q <= '0;
						bad_q <= 1'b0;
					end
					OP_APPEND: begin
						if (sts.full || forbidden) begin
							bad_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (cmd.scan_cmp && (alpha_rdata == sym_q)) begin
				bad_q <= 1'b1;
			end
			if (cmd.write_sym) begin
				len_q <= len_q + LEN_W'(1);
			end
			if (cmd.load_sign || cmd.load_digit || cmd.load_err) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sym_q    <= item.symbol_in;
			idx_q    <= '0;
			neg_q    <= item.number[DATA_W-1];
			mag_q    <= num_mag;
			rem_q    <= '0;
			bitcnt_q <= BIT_W'(DATA_W - 1);
			count_q  <= '0;
		end
		if (cmd.scan_cmp) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.div_step) begin
			mag_q    <= {mag_q[DATA_W-2:0], q_bit};
			rem_q    <= rem_next;
			bitcnt_q <= bitcnt_q - BIT_W'(1);
		end
		if (cmd.push) begin
			if (stack_room) begin
				count_q <= count_q + CNT_W'(1);
			end
			rem_q    <= '0;
			bitcnt_q <= BIT_W'(DATA_W - 1);
		end
		if (cmd.pop) begin
			count_q <= pop_ptr;
		end
		if (cmd.load_sign) begin
			result_q <= '{symbol_out: SYM_MINUS, last: 1'b0, error: 1'b0};
		end else if (cmd.load_digit) begin
			result_q <= '{symbol_out: alpha_rdata, last: (count_q == '0), error: 1'b0};
		end else if (cmd.load_err) begin
			result_q <= '{symbol_out: '0, last: 1'b1, error: 1'b1};
		end
	end

	always_comb begin
		sts.full       = (len_q >= LEN_W'(MAX_SYMBOLS));
		sts.len_zero   = (len_q == '0);
		sts.invalid    = bad_q || (len_q < LEN_W'(2));
		sts.neg        = neg_q;
		sts.scan_last  = ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);
		sts.bit_last   = (bitcnt_q == '0);
		sts.mag_zero   = (mag_q == '0);
		sts.count_zero = (count_q == '0);
		sts.out_free   = !result_valid_q || !result_stall;
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule
`default_nettype wire

>>> rtl/core/integer_to_radix_digits.sv
// Top level of the radix digit formatter: controller, datapath and port checks.
//
// Items arrive on the item channel (item_valid / item_stall); each beat carries an op,
// a symbol byte and a signed 32-bit number. Clear finishes in the cycle it is taken.
// Append scans the stored alphabet for a duplicate through its single read port, a
// read step and a compare step per stored symbol, then writes unless it is full.
// Convert divides the magnitude by the radix with a bit-serial restoring divider, a
// divide step per dividend bit and a push of the remainder per digit, then emits
// each symbol through pop, lookup and emit steps. Results leave one character per
// beat on the result channel (result_valid / result_stall), most significant first,
// with '-' ahead of a negative number and last set on the final beat. An invalid
// alphabet gives one beat with error and last set. The output register holds a beat
// while result_stall is high, and the sign, digit and error output steps wait on it;
// the next item is taken as soon as the last beat is loaded. Reset empties the
// alphabet and clears the output valid flag; no clearing pass.
`default_nettype none
module integer_to_radix_digits import itrd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	cmd_t cmd;
	sts_t sts;

	itrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_op   (item.op),
		.sts       (sts),
		.item_stall(item_stall),
		.cmd       (cmd)
	);

	itrd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.result_stall(result_stall),
		.cmd         (cmd),
		.sts         (sts),
		.result      (result),
		.result_valid(result_valid)
	);

	// An error beat is always a lone, zero-symbol final beat.
	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.error) |-> (result.last && (result.symbol_out == '0)))
		else $error("error beat without last or with a nonzero symbol");

	// A good alphabet never holds '-', so a sign beat is never the final beat.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.error && (result.symbol_out == SYM_MINUS)) |-> !result.last)
		else $error("sign beat marked last");

	// A convert always occupies the block for at least the following cycle.
	a_convert_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && (item.op == OP_CONVERT)) |=> item_stall)
		else $error("convert accepted without going busy");

	// A clear finishes in the cycle it is taken.
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && (item.op == OP_CLEAR)) |=> !item_stall)
		else $error("clear left the block busy");

endmodule
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the radix digit formatter: a directed table, then random alphabet rounds.
module testbench import itrd_pkg::*; ();

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 410;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_CYCLES = 1500;
	localparam result_t BAD_ALPHABET = '{symbol_out: 8'h00, last: 1'b1, error: 1'b1};
	localparam result_t ZERO_DIGIT = '{symbol_out: "0", last: 1'b1, error: 1'b0};
	localparam logic [SYM_W-1:0] FORBIDDEN_SYMS [8] = '{SYM_PLUS, SYM_MINUS, SYM_PERCENT,
		SYM_SLASH, SYM_STAR, SYM_EQUAL, SYM_COMMA, SYM_DOT};

	typedef struct {
		item_t   beat;
		bit      typed;
		result_t answer;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	// Formatter state as the block should hold it.
	logic [SYM_W-1:0] model_alphabet [MAX_SYMBOLS];
	int unsigned model_length = 0;
	bit model_bad = 1'b0;

	result_t pending_chars [$];
	int mismatches = 0;
	int beats_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	directed_row_t directed_rows [23] = '{
		'{'{OP_CONVERT, 8'h00, 32'sd0}, 1'b1, BAD_ALPHABET},
		'{'{OP_CLEAR, 8'h00, 32'sd0}, 1'b0, '0},
		'{'{OP_APPEND, "0", 32'sd0}, 1'b0, '0},
		'{'{OP_CONVERT, 8'h00, 32'sd7}, 1'b1, BAD_ALPHABET},
		'{'{OP_APPEND, "1", 32'sd0}, 1'b0, '0},
		'{'{OP_CONVERT, 8'h00, 32'sd0}, 1'b1, ZERO_DIGIT},
		'{'{OP_CONVERT, 8'h00, 32'hFFFFFFFF}, 1'b0, '0},
		'{'{OP_CONVERT, 8'h00, 32'h7FFFFFFF}, 1'b0, '0},
		'{'{OP_CONVERT, 8'h00, 32'h80000000}, 1'b0, '0},
		'{'{OP_UNUSED, 8'hFF, 32'hFFFFFFFF}, 1'b0, '0},
		'{'{OP_APPEND, "1", 32'sd0}, 1'b0, '0},
		'{'{OP_CONVERT, 8'h00, 32'sd5}, 1'b1, BAD_ALPHABET},
		'{'{OP_CLEAR, 8'h00, 32'sd0}, 1'b0, '0},
		'{'{OP_APPEND, SYM_LOW, 32'sd0}, 1'b0, '0},
		'{'{OP_APPEND, SYM_HIGH, 32'sd0}, 1'b0, '0},
		'{'{OP_CONVERT, 8'h00, 32'sd5}, 1'b0, '0},
		'{'{OP_CONVERT, 8'h00, -32'sd5}, 1'b0, '0},
		'{'{OP_APPEND, SYM_PLUS, 32'sd0}, 1'b0, '0},
		'{'{OP_CONVERT, 8'h00, 32'sd1}, 1'b1, BAD_ALPHABET},
		'{'{OP_CLEAR, 8'h00, 32'sd0}, 1'b0, '0},
		'{'{OP_APPEND, 8'd32, 32'sd0}, 1'b0, '0},
		'{'{OP_APPEND, "Q", 32'sd0}, 1'b0, '0},
		'{'{OP_CONVERT, 8'h00, 32'sd0}, 1'b1, BAD_ALPHABET}
	};

	integer_to_radix_digits u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit symbol_rejected(input logic [SYM_W-1:0] sym);
		return sym < SYM_LOW || sym > SYM_HIGH || sym inside {SYM_PLUS, SYM_MINUS, SYM_PERCENT,
			SYM_SLASH, SYM_STAR, SYM_EQUAL, SYM_COMMA, SYM_DOT};
	endfunction

	function automatic item_t make_item(input logic [1:0] op, input logic [SYM_W-1:0] sym,
			input logic signed [DATA_W-1:0] num);
		item_t it;
		it.op = op;
		it.symbol_in = sym;
		it.number = num;
		return it;
	endfunction

	function automatic logic [SYM_W-1:0] random_symbol();
		return SYM_W'($urandom_range(255));
	endfunction

	function automatic logic signed [DATA_W-1:0] random_number();
		case ($urandom_range(5))
		0: return $urandom_range(20);
		1: return 32'd0 - $urandom_range(20);
		2: case ($urandom_range(4))
			0: return 32'sd0;
			1: return 32'sd1;
			2: return 32'hFFFFFFFF;
			3: return 32'h7FFFFFFF;
			default: return 32'h80000000;
			endcase
		default: return $urandom;
		endcase
	endfunction

	// Updates the alphabet state and lists the characters one item should produce.
	task automatic predict_chars(input item_t it, output result_t chars [$]);
		logic [DATA_W-1:0] mag;
		int unsigned radix;
		int unsigned digits [$];
		int unsigned d;
		result_t ch;
		chars = {};
		case (it.op)
		OP_CLEAR: begin
			model_length = 0;
			model_bad = 1'b0;
		end
		OP_APPEND: begin
			if (model_length >= MAX_SYMBOLS) model_bad = 1'b1;
			else begin
				if (symbol_rejected(it.symbol_in)) model_bad = 1'b1;
				for (int i = 0; i < model_length; i++)
					if (model_alphabet[i] == it.symbol_in) model_bad = 1'b1;
				model_alphabet[model_length] = it.symbol_in;
				model_length++;
			end
		end
		OP_CONVERT: begin
			if (model_bad || model_length < 2) chars.push_back(BAD_ALPHABET);
			else begin
				radix = model_length;
				// The most negative value negates to its own pattern, read as unsigned.
				mag = it.number[DATA_W-1] ? 32'd0 - it.number : it.number;
				do begin
					digits.push_front(mag % radix);
					mag = mag / radix;
				end while (mag != 0);
				if (it.number[DATA_W-1]) begin
					ch = '{symbol_out: SYM_MINUS, last: 1'b0, error: 1'b0};
					chars.push_back(ch);
				end
				while (digits.size() != 0) begin
					d = digits.pop_front();
					ch.symbol_out = model_alphabet[d];
					ch.last = (digits.size() == 0);
					ch.error = 1'b0;
					chars.push_back(ch);
				end
			end
		end
		default: ;
		endcase
	endtask

	task automatic send_item(input item_t it, input bit typed = 1'b0, input result_t answer = '0);
		result_t chars [$];
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predict_chars(it, chars);
		if (typed) pending_chars.push_back(answer);
		else foreach (chars[i]) pending_chars.push_back(chars[i]);
		if (it.op != OP_UNUSED) beats_sent++;
	endtask

	task automatic drain_pause();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_chars.size() != 0);
	endtask

	// Clear, load distinct legal symbols (optionally with one bad append), then convert.
	task automatic alphabet_round(input int size, input bit spoil);
		logic [SYM_W-1:0] pool [$];
		logic [SYM_W-1:0] used [$];
		logic [SYM_W-1:0] sym;
		int pick;
		int spoil_at;
		for (int s = SYM_LOW; s <= SYM_HIGH; s++)
			if (!symbol_rejected(SYM_W'(s))) pool.push_back(SYM_W'(s));
		if (size == 0)
			size = ($urandom_range(9) == 0) ? $urandom_range(2, pool.size()) : $urandom_range(2, 12);
		spoil_at = $urandom_range(size);
		send_item(make_item(OP_CLEAR, random_symbol(), $urandom));
		for (int i = 0; i <= size; i++) begin
			if (spoil && i == spoil_at) begin
				case ($urandom_range(2))
				0: sym = (used.size() != 0) ? used[$urandom_range(used.size() - 1)] : SYM_MINUS;
				1: sym = FORBIDDEN_SYMS[$urandom_range(7)];
				default: sym = $urandom_range(1) ? SYM_W'($urandom_range(32)) :
					SYM_W'($urandom_range(255, 127));
				endcase
				send_item(make_item(OP_APPEND, sym, $urandom));
			end
			if (i < size) begin
				pick = $urandom_range(pool.size() - 1);
				sym = pool[pick];
				pool.delete(pick);
				used.push_back(sym);
				send_item(make_item(OP_APPEND, sym, $urandom));
			end
		end
		repeat ($urandom_range(1, 6))
			send_item(make_item(OP_CONVERT, random_symbol(), random_number()));
	endtask

	initial begin
		bit overfilled;
		int choice;
		overfilled = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_item(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].answer);

		// A long receiver hold during radix-2 conversions backs the block up into its input.
		hold_request = 1'b1;
		alphabet_round(2, 1'b0);
		repeat (3) send_item(make_item(OP_CONVERT, 8'h00, random_number()));
		drain_pause();

		while (beats_sent < ITEM_TARGET) begin
			// Idling settings rotate every 50 beats.
			case ((beats_sent / 50) % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 51;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 51;
			end
			default: begin
				send_idle_pct = 31;
				recv_stall_pct = 31;
			end
			endcase
			if (!overfilled && beats_sent > ITEM_TARGET / 2) begin
				// Appends past capacity must leave the alphabet marked bad.
				drain_pause();
				send_item(make_item(OP_CLEAR, 8'h00, 32'sd0));
				repeat (MAX_SYMBOLS + 2) send_item(make_item(OP_APPEND, random_symbol(), 32'sd0));
				send_item(make_item(OP_CONVERT, 8'h00, random_number()));
				overfilled = 1'b1;
			end
			choice = $urandom_range(19);
			if (choice < 14) alphabet_round(0, 1'b0);
			else if (choice < 17) alphabet_round(0, 1'b1);
			else repeat ($urandom_range(1, 4))
				send_item(make_item(2'($urandom_range(3)), random_symbol(), $urandom));
		end
		item_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected beat: symbol_out %h last %b error %b",
					result.symbol_out, result.last, result.error);
				mismatches++;
			end else begin
				want = pending_chars.pop_front();
				if (result.symbol_out !== want.symbol_out) begin
					$error("symbol_out: expected %h, got %h", want.symbol_out, result.symbol_out);
					mismatches++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %b, got %b", want.last, result.last);
					mismatches++;
				end
				if (result.error !== want.error) begin
					$error("error: expected %b, got %b", want.error, result.error);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#(40_000_000);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
